// File: rtl/preamble_length_deframer_macros.svh
// assertion macros for the preamble length deframer
`ifndef PREAMBLE_LENGTH_DEFRAMER_MACROS_SVH
`define PREAMBLE_LENGTH_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define PLDF_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("pldf assertion failed");
// expression must never be true outside reset
`define PLDF_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
		else $error("pldf forbidden condition seen");
`else
`define PLDF_ASSERT(label, clk, rst_n, prop)
`define PLDF_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// File: rtl/pldf_pkg.sv
`timescale 1ns / 1ps
package pldf_pkg;

	localparam int PLDF_BYTE_W = 8;
	localparam int PLDF_PATTERN_W = 64;
	localparam int PLDF_LEN_W = 16;
	localparam int PLDF_PREAMBLE_BYTES = 8;
	localparam int PLDF_PREAMBLE_BYTES_MAX = PLDF_PATTERN_W / PLDF_BYTE_W;
	localparam int PLDF_MATCH_W = $clog2(PLDF_PREAMBLE_BYTES_MAX + 1);
	localparam logic [PLDF_PATTERN_W-1:0] PLDF_PREAMBLE_RESET = 64'h5445535444415441;

	// one byte held in the input register
	typedef struct packed {
		logic                   valid;
		logic [PLDF_BYTE_W-1:0] data;
	} pldf_beat_t;

	// parser state exported for checking
	typedef struct packed {
		logic                    advance;
		logic                    in_payload;
		logic [PLDF_MATCH_W-1:0] match_count;
		logic [PLDF_LEN_W-1:0]   frame_length;
		logic [PLDF_LEN_W-1:0]   payload_count;
	} pldf_status_t;

endpackage

// File: rtl/pldf_in_stage.sv
`timescale 1ns / 1ps
module pldf_in_stage import pldf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	output logic                   s_ready,
	input  logic [PLDF_BYTE_W-1:0] s_data,
	input  logic                   take,
	output pldf_beat_t             beat_s1
);

	logic                   valid_s1;
	logic [PLDF_BYTE_W-1:0] data_s1;

	assign s_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_ready) begin
			valid_s1 <= s_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_valid && s_ready) begin
			data_s1 <= s_data;
		end
	end

	assign beat_s1.valid = valid_s1;
	assign beat_s1.data  = data_s1;

endmodule

// File: rtl/pldf_parser.sv
`timescale 1ns / 1ps
module pldf_parser import pldf_pkg::*; #(
	parameter int PREAMBLE_BYTES = PLDF_PREAMBLE_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [PLDF_PATTERN_W-1:0] cfg_wr_data,
	input  pldf_beat_t                beat_s1,
	output logic                      take,
	output logic                      m_valid,
	input  logic                      m_ready,
	output logic [PLDF_BYTE_W-1:0]    m_data,
	output logic                      m_last,
	output pldf_status_t              status
);

	localparam int MW = (PREAMBLE_BYTES > 1) ? $clog2(PREAMBLE_BYTES) : 1;
	localparam logic [MW-1:0] MATCH_LAST = MW'(PREAMBLE_BYTES - 1);

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_LEN_HI  = 4'b0010,
		PH_LEN_LO  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} pldf_phase_t;

	pldf_phase_t                phase_q, phase_d;
	logic [MW-1:0]              match_q, match_d;
	logic [PLDF_LEN_W-1:0]      frame_len_q, frame_len_d;
	logic [PLDF_LEN_W-1:0]      pay_cnt_q, pay_cnt_d;
	logic [PLDF_LEN_W-1:0]      pay_cnt_inc;
	logic [PLDF_PATTERN_W-1:0]  pattern_q;
	logic [PLDF_BYTE_W-1:0]     pre_byte [PREAMBLE_BYTES];
	logic [PLDF_BYTE_W-1:0]     exp_byte;
	logic                       out_valid_q, out_last_q;
	logic [PLDF_BYTE_W-1:0]     out_data_q;
	logic                       out_free, emit, emit_last;

	always_comb begin
		for (int i = 0; i < PREAMBLE_BYTES; i++) begin
			pre_byte[i] = pattern_q[PLDF_PATTERN_W-1 - i*PLDF_BYTE_W -: PLDF_BYTE_W];
		end
	end

	assign exp_byte    = pre_byte[match_q];
	assign pay_cnt_inc = pay_cnt_q + PLDF_LEN_W'(1);
	assign out_free    = !out_valid_q || m_ready;
	assign take        = beat_s1.valid && ((phase_q != PH_PAYLOAD) || out_free);
	assign emit        = take && (phase_q == PH_PAYLOAD);
	assign emit_last   = (pay_cnt_inc == frame_len_q);

	always_comb begin
		phase_d     = phase_q;
		match_d     = match_q;
		frame_len_d = frame_len_q;
		pay_cnt_d   = pay_cnt_q;
		case (phase_q)
			PH_HUNT: begin
				if (beat_s1.data == exp_byte) begin
					if (match_q == MATCH_LAST) begin
						match_d = '0;
						phase_d = PH_LEN_HI;
					end else begin
						match_d = match_q + MW'(1);
					end
				end else begin
					match_d = '0;
				end
			end
			PH_LEN_HI: begin
				frame_len_d = {beat_s1.data, frame_len_q[PLDF_BYTE_W-1:0]};
				match_d     = '0;
				phase_d     = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				frame_len_d = {frame_len_q[PLDF_LEN_W-1:PLDF_BYTE_W], beat_s1.data};
				if (frame_len_d != '0) begin
					pay_cnt_d = '0;
					phase_d   = PH_PAYLOAD;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				pay_cnt_d = pay_cnt_inc;
				if (emit_last) begin
					phase_d = PH_HUNT;
					match_d = '0;
				end
			end
			default: begin
				phase_d = PH_HUNT;
				match_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			match_q     <= '0;
			frame_len_q <= '0;
			pay_cnt_q   <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			match_q     <= match_d;
			frame_len_q <= frame_len_d;
			pay_cnt_q   <= pay_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= PLDF_PREAMBLE_RESET;
		end else if (cfg_wr_en) begin
			pattern_q <= cfg_wr_data;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= beat_s1.data;
			out_last_q <= emit_last;
		end
	end

	assign m_valid = out_valid_q;
	assign m_data  = out_data_q;
	assign m_last  = out_last_q;

	assign status.advance       = take;
	assign status.in_payload    = (phase_q == PH_PAYLOAD);
	assign status.match_count   = PLDF_MATCH_W'(match_q);
	assign status.frame_length  = frame_len_q;
	assign status.payload_count = pay_cnt_q;

endmodule

// File: rtl/preamble_length_deframer.sv
`timescale 1ns / 1ps
// Byte stream deframer: hunts for a programmable preamble (cfg_wr_data, first byte in
// bits 63..56, top PREAMBLE_BYTES bytes used), reads a 16-bit big-endian length and
// forwards that many payload bytes with tlast on the final one; a zero length goes back
// to hunting. One byte is taken every clock cycle unless the input stalls, which
// happens only while a payload byte waits for a full result register. Each byte passes
// an input register and one compare-and-count step; a payload byte then passes a result
// register before it reaches m_axis. Write the preamble only while the block is idle.
`include "preamble_length_deframer_macros.svh"
module preamble_length_deframer import pldf_pkg::*; #(
	parameter int PREAMBLE_BYTES = PLDF_PREAMBLE_BYTES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [PLDF_PATTERN_W-1:0] cfg_wr_data,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [PLDF_BYTE_W-1:0]    s_axis_tdata,   // [7:0] rx_byte
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [PLDF_BYTE_W-1:0]    m_axis_tdata,   // [7:0] payload_byte
	output logic                      m_axis_tlast    // frame_end
);

	pldf_beat_t   beat_s1;
	pldf_status_t status;
	logic         take;

	pldf_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.s_data  (s_axis_tdata),
		.take    (take),
		.beat_s1 (beat_s1)
	);

	pldf_parser #(
		.PREAMBLE_BYTES (PREAMBLE_BYTES)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.beat_s1     (beat_s1),
		.take        (take),
		.m_valid     (m_axis_tvalid),
		.m_ready     (m_axis_tready),
		.m_data      (m_axis_tdata),
		.m_last      (m_axis_tlast),
		.status      (status)
	);

	`PLDF_ASSERT(a_ready_only_blocked_by_held_beat, clk, arst_n, !s_axis_tready |-> beat_s1.valid)
	`PLDF_ASSERT(a_payload_count_below_length, clk, arst_n, status.in_payload |-> (status.payload_count < status.frame_length))
	`PLDF_ASSERT(a_match_count_in_range, clk, arst_n, status.match_count < PLDF_MATCH_W'(PREAMBLE_BYTES))
	`PLDF_ASSERT_NEVER(a_no_payload_over_stalled_result, clk, arst_n, m_axis_tvalid && !m_axis_tready && status.in_payload && status.advance)

endmodule
